[design/assert_macros.svh]
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Checks that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

[design/lifegrid_pkg.sv]
// Types and constants shared by the life grid modules.
package lifegrid_pkg;

  typedef enum logic [1:0] {
    CMD_SET  = 2'd0,
    CMD_READ = 2'd1,
    CMD_STEP = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ADDR_ITEM,
    ADDR_FIRST,
    ADDR_SECOND,
    ADDR_AHEAD
  } addr_sel_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_CELL_RD,
    ST_CELL_UPD,
    ST_STEP_RD0,
    ST_STEP_RD1,
    ST_STEP_RUN,
    ST_DONE
  } state_t;

  // Neighbor counts of rule B3/S23.
  localparam logic [3:0] LIFE_BIRTH   = 4'd3;
  localparam logic [3:0] LIFE_SURVIVE = 4'd2;

  typedef struct packed {
    logic      capture;
    logic      rd_en;
    addr_sel_t addr_sel;
    logic      cell_wr;
    logic      step_init;
    logic      step_load;
    logic      step_run;
    logic      res_load;
    logic      out_load;
  } dp_cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic in_grid;
    logic last_row;
    logic ahead_ok;
  } dp_status_t;

endpackage

[design/life_cellular_automaton_grid.sv]
// Top level of the Game of Life grid: controller, datapath and row memory.
// A set or read reads its cell's row (a set then rewrites it) before its result, a command
// addressing outside the grid or an unused command skips the memory, and a step sweeps all rows.
// A new item waits until the last is done, as a step sweeps the grid one row per cycle
// through the single write port of the row memory. The next item is accepted while a
// result waits. Reset clears the per-row valid bits, so the whole grid reads dead at once.
`include "assert_macros.svh"

module life_cellular_automaton_grid import lifegrid_pkg::*; #(
  parameter int ROWS = 64,
  parameter int COLS = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] command,
  input  logic [5:0] row_index,
  input  logic [5:0] col_index,
  input  logic       cell_value,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       alive
);

  localparam int RW = $clog2(ROWS);

  dp_cmd_t         ctl;
  dp_status_t      stat;
  logic            ram_wr_en;
  logic [RW-1:0]   ram_wr_addr;
  logic [COLS-1:0] ram_wr_data;
  logic            ram_rd_en;
  logic [RW-1:0]   ram_rd_addr;
  logic [COLS-1:0] ram_rd_data;

  // The controller owns both handshakes and the order of memory accesses.
  lifegrid_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .ctl       (ctl)
  );

  // The datapath holds the transaction fields, a three-row window during a step,
  // and the output register that keeps a finished result apart from new work.
  lifegrid_dp #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .command     (command),
    .row_index   (row_index),
    .col_index   (col_index),
    .cell_value  (cell_value),
    .ctl         (ctl),
    .stat        (stat),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .ram_rd_en   (ram_rd_en),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data),
    .alive       (alive)
  );

  // One memory word is one grid row, so a step reads and writes a row a cycle.
  lifegrid_ram #(
    .WIDTH (COLS),
    .DEPTH (ROWS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // An accepted transaction keeps the block busy in the following cycle.
  `ASSERT_NEXT(a_accept_then_busy, clk, rst, in_valid && !in_stall, in_stall)
  // A row is never read in the same cycle that it is rewritten.
  `ASSERT_IMPLIES(a_no_rw_same_row, clk, rst, ram_wr_en && ram_rd_en, ram_wr_addr != ram_rd_addr)
  // The grid changes only while a transaction is being worked on.
  `ASSERT_IMPLIES(a_write_when_busy, clk, rst, ram_wr_en, in_stall)
  // A new result is loaded only when the output register is free.
  `ASSERT_IMPLIES(a_load_when_free, clk, rst, ctl.out_load, !(out_valid && out_stall))

endmodule

[design/lifegrid_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module lifegrid_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[design/lifegrid_ctrl.sv]
// Controller state machine that sequences cell accesses and generation sweeps.
module lifegrid_ctrl import lifegrid_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  dp_status_t stat,
  output dp_cmd_t    ctl
);

  state_t state;
  state_t state_next;
  logic   out_valid_next;
  logic   out_free;

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if ((stat.cmd == CMD_SET || stat.cmd == CMD_READ) && stat.in_grid) begin
          state_next = ST_CELL_RD;
        end else if (stat.cmd == CMD_STEP) begin
          state_next = ST_STEP_RD0;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_CELL_RD:  state_next = ST_CELL_UPD;
      ST_CELL_UPD: state_next = ST_DONE;
      ST_STEP_RD0: state_next = ST_STEP_RD1;
      ST_STEP_RD1: state_next = ST_STEP_RUN;
      ST_STEP_RUN: begin
        if (stat.last_row) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl      = '0;
    in_stall = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        ctl.capture = in_valid;
      end
      ST_CELL_RD: begin
        ctl.rd_en    = 1'b1;
        ctl.addr_sel = ADDR_ITEM;
      end
      ST_CELL_UPD: begin
        ctl.res_load = 1'b1;
        ctl.cell_wr  = (stat.cmd == CMD_SET);
      end
      ST_STEP_RD0: begin
        ctl.rd_en     = 1'b1;
        ctl.addr_sel  = ADDR_FIRST;
        ctl.step_init = 1'b1;
      end
      ST_STEP_RD1: begin
        ctl.rd_en     = 1'b1;
        ctl.addr_sel  = ADDR_SECOND;
        ctl.step_load = 1'b1;
      end
      ST_STEP_RUN: begin
        ctl.rd_en    = stat.ahead_ok;
        ctl.addr_sel = ADDR_AHEAD;
        ctl.step_run = 1'b1;
      end
      ST_DONE: begin
        ctl.out_load = out_free;
      end
      default: ctl = '0;
    endcase
  end

  assign out_valid_next = ctl.out_load || (out_valid && out_stall);

endmodule

[design/lifegrid_dp.sv]
// Datapath: item registers, row window, row of next-generation cells, result registers.
module lifegrid_dp import lifegrid_pkg::*; #(
  parameter int ROWS = 64,
  parameter int COLS = 64
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [1:0]              command,
  input  logic [5:0]              row_index,
  input  logic [5:0]              col_index,
  input  logic                    cell_value,
  input  dp_cmd_t                 ctl,
  output dp_status_t              stat,
  output logic                    ram_wr_en,
  output logic [$clog2(ROWS)-1:0] ram_wr_addr,
  output logic [COLS-1:0]         ram_wr_data,
  output logic                    ram_rd_en,
  output logic [$clog2(ROWS)-1:0] ram_rd_addr,
  input  logic [COLS-1:0]         ram_rd_data,
  output logic                    alive
);

  localparam int RW  = $clog2(ROWS);
  localparam int CW  = $clog2(COLS);
  localparam int RXW = (RW > 6) ? RW : 6;
  localparam int CXW = (CW > 6) ? CW : 6;

  cmd_t            cmd_q;
  logic [5:0]      row_q;
  logic [5:0]      col_q;
  logic            val_q;
  logic            res_work;
  logic            alive_q;
  logic [ROWS-1:0] row_valid;
  logic            rd_live;
  logic [COLS-1:0] above;
  logic [COLS-1:0] cur;
  logic [RW-1:0]   step_row;

  logic [RXW-1:0]  row_ext;
  logic [CXW-1:0]  col_ext;
  logic [RW-1:0]   row_idx;
  logic [CW-1:0]   col_idx;
  logic [COLS-1:0] rd_row;
  logic [COLS-1:0] set_row;
  logic [COLS-1:0] next_row;
  logic [COLS+1:0] pad_above;
  logic [COLS+1:0] pad_cur;
  logic [COLS+1:0] pad_below;

  assign row_ext = RXW'(row_q);
  assign col_ext = CXW'(col_q);
  assign row_idx = row_ext[RW-1:0];
  assign col_idx = col_ext[CW-1:0];

  // Rows never written since reset read as all dead.
  assign rd_row = rd_live ? ram_rd_data : '0;

  assign stat.cmd      = cmd_q;
  assign stat.in_grid  = (32'(row_q) < 32'(ROWS)) && (32'(col_q) < 32'(COLS));
  assign stat.last_row = (step_row == RW'(ROWS - 1));
  assign stat.ahead_ok = (32'(step_row) + 32'd2) < 32'(ROWS);

  always_comb begin
    case (ctl.addr_sel)
      ADDR_ITEM:   ram_rd_addr = row_idx;
      ADDR_FIRST:  ram_rd_addr = '0;
      ADDR_SECOND: ram_rd_addr = RW'(1);
      ADDR_AHEAD:  ram_rd_addr = step_row + RW'(2);
      default:     ram_rd_addr = '0;
    endcase
  end
  assign ram_rd_en = ctl.rd_en;

  always_comb begin
    set_row          = rd_row;
    set_row[col_idx] = val_q;
  end

  // Border cells outside the grid are dead.
  assign pad_above = {1'b0, above, 1'b0};
  assign pad_cur   = {1'b0, cur, 1'b0};
  assign pad_below = {1'b0, rd_row, 1'b0};

  for (genvar c = 0; c < COLS; c++) begin : g_cell
    logic [3:0] nbr;
    assign nbr = 4'(pad_above[c]) + 4'(pad_above[c+1]) + 4'(pad_above[c+2])
               + 4'(pad_cur[c]) + 4'(pad_cur[c+2])
               + 4'(pad_below[c]) + 4'(pad_below[c+1]) + 4'(pad_below[c+2]);
    assign next_row[c] = (nbr == LIFE_BIRTH) || ((nbr == LIFE_SURVIVE) && cur[c]);
  end

  assign ram_wr_en   = ctl.cell_wr || ctl.step_run;
  assign ram_wr_addr = ctl.step_run ? step_row : row_idx;
  assign ram_wr_data = ctl.step_run ? next_row : set_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rd_live   <= 1'b0;
      step_row  <= '0;
    end else begin
      rd_live <= ctl.rd_en && row_valid[ram_rd_addr];
      if (ram_wr_en) begin
        row_valid[ram_wr_addr] <= 1'b1;
      end
      if (ctl.step_init) begin
        step_row <= '0;
      end else if (ctl.step_run) begin
        step_row <= step_row + RW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_q    <= cmd_t'(command);
      row_q    <= row_index;
      col_q    <= col_index;
      val_q    <= cell_value;
      res_work <= 1'b0;
    end else if (ctl.res_load) begin
      res_work <= (cmd_q == CMD_SET) ? val_q : rd_row[col_idx];
    end
    if (ctl.step_init) begin
      above <= '0;
    end else if (ctl.step_run) begin
      above <= cur;
    end
    if (ctl.step_load || ctl.step_run) begin
      cur <= rd_row;
    end
    if (ctl.out_load) begin
      alive_q <= res_work;
    end
  end

  assign alive = alive_q;

endmodule
